### design/frx_pkg.sv
// Shared types and constants of the framed packet receiver.
`timescale 1ns / 1ps

package frx_pkg;

  localparam int FRX_MAX_LEN = 16;
  localparam logic [7:0] FRX_START_BYTE = 8'hAA;
  localparam logic [31:0] FRX_TIMEOUT_RESET = 32'd50;

  localparam logic [1:0] ST_BUSY = 2'd0;
  localparam logic [1:0] ST_GOOD = 2'd1;
  localparam logic [1:0] ST_CRC = 2'd2;
  localparam logic [1:0] ST_TIMEOUT = 2'd3;

  typedef struct packed {
    logic gap_over;
    logic is_start;
    logic len_over;
    logic byte_len_zero;
    logic held_len_zero;
    logic data_done;
    logic csum_ok;
    logic pos_last;
  } frx_stat_t;

  typedef struct packed {
    logic load_time;
    logic load_cmd;
    logic load_len;
    logic store_byte;
    logic clear_frame;
    logic out_load;
    logic [1:0] out_kind;
    logic out_payload;
    logic pos_step;
  } frx_cmd_t;

endpackage

### design/frx_ctrl.sv
// Parser state machine and output handshake control of the frame receiver.
`timescale 1ns / 1ps

module frx_ctrl import frx_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  input  frx_stat_t stat,
  output frx_cmd_t  cmd
);

  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_CMD = 3'd1;
  localparam logic [2:0] PH_LEN = 3'd2;
  localparam logic [2:0] PH_DATA = 3'd3;
  localparam logic [2:0] PH_CHECK = 3'd4;
  localparam logic [2:0] PH_DRAIN = 3'd5;

  logic [2:0] phase;
  logic [2:0] phase_next;
  logic       out_valid_next;
  logic       out_free;
  logic       in_fire;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (phase != PH_DRAIN) && out_free;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    phase_next = phase;
    cmd = '0;
    cmd.out_kind = ST_BUSY;
    if (phase == PH_DRAIN) begin
      if (out_free) begin
        cmd.out_load = 1'b1;
        cmd.out_kind = ST_GOOD;
        cmd.out_payload = 1'b1;
        cmd.pos_step = 1'b1;
        if (stat.pos_last) begin
          phase_next = PH_WAIT;
        end
      end
    end else if (in_fire) begin
      cmd.out_load = 1'b1;
      if (stat.gap_over && phase != PH_WAIT) begin
        // drop the byte, keep the previous arrival time
        cmd.clear_frame = 1'b1;
        cmd.out_kind = ST_TIMEOUT;
        phase_next = PH_WAIT;
      end else begin
        cmd.load_time = 1'b1;
        case (phase)
          PH_WAIT: begin
            if (stat.is_start) begin
              phase_next = PH_CMD;
            end
          end
          PH_CMD: begin
            cmd.load_cmd = 1'b1;
            phase_next = PH_LEN;
          end
          PH_LEN: begin
            if (stat.len_over) begin
              cmd.clear_frame = 1'b1;
              phase_next = PH_WAIT;
            end else begin
              cmd.load_len = 1'b1;
              phase_next = stat.byte_len_zero ? PH_CHECK : PH_DATA;
            end
          end
          PH_DATA: begin
            cmd.store_byte = 1'b1;
            if (stat.data_done) begin
              phase_next = PH_CHECK;
            end
          end
          PH_CHECK: begin
            phase_next = PH_WAIT;
            if (!stat.csum_ok) begin
              cmd.clear_frame = 1'b1;
              cmd.out_kind = ST_CRC;
            end else if (stat.held_len_zero) begin
              cmd.out_kind = ST_GOOD;
            end else begin
              // payload results follow from the store
              cmd.out_load = 1'b0;
              phase_next = PH_DRAIN;
            end
          end
          default: begin
            cmd.clear_frame = 1'b1;
            phase_next = PH_WAIT;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_WAIT;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### design/frx_datapath.sv
// Frame registers, payload store, timeout check and result register of the receiver.
`timescale 1ns / 1ps

module frx_datapath import frx_pkg::*; #(
  parameter int MAX_LEN = FRX_MAX_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  logic [31:0] arrival_time,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  frx_cmd_t    cmd,
  output frx_stat_t   stat,
  output logic [1:0]  status,
  output logic [7:0]  frame_command,
  output logic [4:0]  frame_length,
  output logic [7:0]  payload_byte,
  output logic [3:0]  payload_position,
  output logic        last
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int IW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

  logic [31:0]   timeout_limit;
  logic [31:0]   last_arrival;
  logic [7:0]    held_command;
  logic [LW-1:0] held_length;
  logic [LW-1:0] payload_count;
  logic [7:0]    running_checksum;
  logic [IW-1:0] pos;
  logic [IW-1:0] pos_next;
  logic [7:0]    rd_data;
  logic [7:0]    payload_store [MAX_LEN];
  logic [31:0]   gap;
  logic [LW-1:0] count_inc;

  assign gap = arrival_time - last_arrival;
  assign count_inc = payload_count + LW'(1);

  always_comb begin
    stat.gap_over = (timeout_limit != 32'd0) && (gap > timeout_limit);
    stat.is_start = data_byte == FRX_START_BYTE;
    stat.len_over = data_byte > 8'(MAX_LEN);
    stat.byte_len_zero = data_byte == 8'd0;
    stat.held_len_zero = held_length == '0;
    stat.data_done = count_inc >= held_length;
    stat.csum_ok = data_byte == running_checksum;
    stat.pos_last = (LW'(pos) + LW'(1)) == held_length;
  end

  always_comb begin
    pos_next = pos;
    if (cmd.pos_step) begin
      pos_next = stat.pos_last ? '0 : pos + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_limit <= FRX_TIMEOUT_RESET;
      last_arrival <= '0;
      held_command <= '0;
      held_length <= '0;
      payload_count <= '0;
      running_checksum <= '0;
      pos <= '0;
    end else begin
      pos <= pos_next;
      if (cfg_write) begin
        timeout_limit <= cfg_data;
      end
      if (cmd.load_time) begin
        last_arrival <= arrival_time;
      end
      if (cmd.clear_frame) begin
        held_command <= '0;
        held_length <= '0;
        payload_count <= '0;
        running_checksum <= '0;
      end else if (cmd.load_cmd) begin
        held_command <= data_byte;
        running_checksum <= data_byte;
      end else if (cmd.load_len) begin
        held_length <= LW'(data_byte);
        running_checksum <= running_checksum ^ data_byte;
        payload_count <= '0;
      end else if (cmd.store_byte) begin
        payload_count <= count_inc;
        running_checksum <= running_checksum ^ data_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      payload_store[payload_count[IW-1:0]] <= data_byte;
    end
    rd_data <= payload_store[pos_next];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_kind;
      frame_command <= (cmd.out_kind == ST_GOOD) ? held_command : 8'd0;
      if (cmd.out_payload) begin
        frame_length <= 5'(held_length);
        payload_byte <= rd_data;
        payload_position <= 4'(pos);
        last <= stat.pos_last;
      end else begin
        frame_length <= '0;
        payload_byte <= '0;
        payload_position <= '0;
        last <= 1'b1;
      end
    end
  end

endmodule

### design/framed_packet_receiver_core.sv
// Top level of the framed packet receiver: byte stream in, frame results out.
`timescale 1ns / 1ps

// Parses frames of start byte 0xAA, command, length (at most MAX_LEN), payload
// and an XOR checksum from a stream of timestamped bytes. Every accepted byte
// gives one result in the cycle after it is taken; a byte is accepted every
// cycle while the result register is free or being emptied. A good frame of
// N > 0 payload bytes instead gives N results, one per cycle while the output
// is not stalled, read from the payload store's registered read port; the first
// comes later than a single result would, and no byte is accepted as they drain.
// A stalled result holds the input back. The timeout register may be written
// at any cycle through the cfg channel, which is always ready.
module framed_packet_receiver_core import frx_pkg::*; #(
  parameter int MAX_LEN = FRX_MAX_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // data_byte [7:0], arrival_time [39:8]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // frame_command [7:0], frame_length [12:8],
                                 // payload_byte [20:13], payload_position [24:21], zero
  output logic [1:0]  m_tuser,   // status [1:0]
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  frx_cmd_t   cmd;
  frx_stat_t  stat;
  logic [7:0] frame_command;
  logic [4:0] frame_length;
  logic [7:0] payload_byte;
  logic [3:0] payload_position;

  assign cfg_ready = 1'b1;

  frx_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .stat      (stat),
    .cmd       (cmd)
  );

  frx_datapath #(
    .MAX_LEN (MAX_LEN)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .data_byte        (s_tdata[7:0]),
    .arrival_time     (s_tdata[39:8]),
    .cfg_write        (cfg_valid && cfg_ready),
    .cfg_data         (cfg_data),
    .cmd              (cmd),
    .stat             (stat),
    .status           (m_tuser),
    .frame_command    (frame_command),
    .frame_length     (frame_length),
    .payload_byte     (payload_byte),
    .payload_position (payload_position),
    .last             (m_tlast)
  );

  assign m_tdata = {7'd0, payload_position, payload_byte, frame_length, frame_command};

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |-> !s_tready)
    else $error("input taken while result stalled");

  a_single_result_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_GOOD |-> m_tlast)
    else $error("non-good result not marked last");

  a_single_result_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != ST_GOOD |-> m_tdata == 32'd0)
    else $error("non-good result carries frame data");

  a_drain_blocks_input: assert property (@(posedge clk) disable iff (rst)
    cmd.out_payload |-> !s_tready)
    else $error("input taken while payload drains");

endmodule
